@@ rtl/scld_pkg.sv @@
// Shared types and constants for the serial command line decoder.
// No dependencies; imported by scld_matcher, the top level and the testbench.
package scld_pkg;

    // Event codes reported once per received byte
    typedef enum logic [3:0] {
        EV_NONE      = 4'd0,
        EV_ECHO      = 4'd1,
        EV_ERASE     = 4'd2,
        EV_VERSION   = 4'd3,
        EV_HELLO     = 4'd4,
        EV_ECHO_ON   = 4'd5,
        EV_ECHO_OFF  = 4'd6,
        EV_BAD_PARAM = 4'd7,
        EV_INVALID   = 4'd8,
        EV_EMPTY     = 4'd9,
        EV_TOO_LONG  = 4'd10
    } scld_event_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SCAN,
        ST_DRAIN,
        ST_DECIDE,
        ST_OUT
    } scld_state_t;

    localparam logic [7:0] CH_CR = 8'h0D;
    localparam logic [7:0] CH_BS = 8'h08;

    // Positions 0..12 cover every character any command or parameter needs
    localparam int SCAN_LEN = 13;
    localparam int POS_W    = 4;

    // Words placed at their line positions in 16 character slots, position 0 in the top byte
    localparam logic [127:0] WORD_VERSION = {"print version", 24'h0};
    localparam logic [127:0] WORD_HELLO   = {"say hello", 56'h0};
    localparam logic [127:0] WORD_ECHO    = {"set echo", 64'h0};
    localparam logic [127:0] WORD_ON      = {72'h0, "on", 40'h0};
    localparam logic [127:0] WORD_OFF     = {72'h0, "off", 32'h0};

    // Bit p set: position p must match
    localparam logic [15:0] MASK_VERSION = 16'h1FFF;
    localparam logic [15:0] MASK_HELLO   = 16'h01FF;
    localparam logic [15:0] MASK_ECHO    = 16'h00FF;
    localparam logic [15:0] MASK_ON      = 16'h0600;
    localparam logic [15:0] MASK_OFF     = 16'h0E00;

    // One compare step: a stored character and whether it lies inside the line
    typedef struct packed {
        logic             valid;
        logic [POS_W-1:0] pos;
        logic [7:0]       data;
        logic             present;
    } scld_cmp_t;

    typedef struct packed {
        logic        echo;
        logic [7:0]  ch;
        scld_event_t ev;
    } scld_res_t;

    function automatic logic [7:0] word_char(input logic [127:0] w,
                                             input logic [POS_W-1:0] p);
        word_char = w[8*(15-p) +: 8];
    endfunction

endpackage

@@ rtl/scld_line_ram.sv @@
// Line buffer storage: one write port, one read port, registered read data.
// Uses no package.
module scld_line_ram #(
    parameter int DEPTH = 64,
    parameter int AW    = 6
) (
    input  logic          aclk,
    input  logic          wr_en,
    input  logic [AW-1:0] wr_addr,
    input  logic [7:0]    wr_data,
    input  logic          rd_en,
    input  logic [AW-1:0] rd_addr,
    output logic [7:0]    rd_data
);

    logic [7:0] mem [DEPTH];
    logic [7:0] rd_data_reg;

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en) begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

@@ rtl/scld_matcher.sv @@
// Prefix matcher: folds one stored character per step into match flags
// for every command and parameter word. Depends on scld_pkg.
module scld_matcher (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  clear,
    input  scld_pkg::scld_cmp_t   cmp,
    output scld_pkg::scld_event_t code
);
    import scld_pkg::*;

    logic ver_ok_reg, ver_ok_next;
    logic hel_ok_reg, hel_ok_next;
    logic ech_ok_reg, ech_ok_next;
    logic on_ok_reg,  on_ok_next;
    logic off_ok_reg, off_ok_next;

    function automatic logic step_ok(input logic [127:0] w, input logic [15:0] m,
                                     input scld_cmp_t c);
        step_ok = !m[c.pos] || (c.present && (c.data == word_char(w, c.pos)));
    endfunction

    always_comb begin
        ver_ok_next = ver_ok_reg;
        hel_ok_next = hel_ok_reg;
        ech_ok_next = ech_ok_reg;
        on_ok_next  = on_ok_reg;
        off_ok_next = off_ok_reg;
        if (clear) begin
            ver_ok_next = 1'b1;
            hel_ok_next = 1'b1;
            ech_ok_next = 1'b1;
            on_ok_next  = 1'b1;
            off_ok_next = 1'b1;
        end else if (cmp.valid) begin
            ver_ok_next = ver_ok_reg & step_ok(WORD_VERSION, MASK_VERSION, cmp);
            hel_ok_next = hel_ok_reg & step_ok(WORD_HELLO, MASK_HELLO, cmp);
            ech_ok_next = ech_ok_reg & step_ok(WORD_ECHO, MASK_ECHO, cmp);
            on_ok_next  = on_ok_reg  & step_ok(WORD_ON, MASK_ON, cmp);
            off_ok_next = off_ok_reg & step_ok(WORD_OFF, MASK_OFF, cmp);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            ver_ok_reg <= 1'b1;
            hel_ok_reg <= 1'b1;
            ech_ok_reg <= 1'b1;
            on_ok_reg  <= 1'b1;
            off_ok_reg <= 1'b1;
        end else begin
            ver_ok_reg <= ver_ok_next;
            hel_ok_reg <= hel_ok_next;
            ech_ok_reg <= ech_ok_next;
            on_ok_reg  <= on_ok_next;
            off_ok_reg <= off_ok_next;
        end
    end

    // First matching command wins
    always_comb begin
        priority if (ver_ok_reg) begin
            code = EV_VERSION;
        end else if (hel_ok_reg) begin
            code = EV_HELLO;
        end else if (ech_ok_reg) begin
            priority if (on_ok_reg) begin
                code = EV_ECHO_ON;
            end else if (off_ok_reg) begin
                code = EV_ECHO_OFF;
            end else begin
                code = EV_BAD_PARAM;
            end
        end else begin
            code = EV_INVALID;
        end
    end

endmodule

@@ rtl/serial_command_line_decoder.sv @@
// Serial command line decoder, top level. Depends on scld_pkg, scld_line_ram, scld_matcher.
// Result path: any byte but a carriage return on a non-empty line goes from ST_IDLE to
//   ST_OUT and then m_tvalid; that one first runs the 13-entry buffer scan (ST_SCAN, ST_DRAIN, ST_DECIDE).
// Flow: one byte at a time; s_tready returns once the result is handed to the output
//   register, and later while the last result still waits on m_tready.
// Reset (aresetn low, synchronous): empty line, echo on, no result pending.
module serial_command_line_decoder #(
    parameter int LINE_MAX = 64
) (
    input  logic        aclk,
    input  logic        aresetn,
    // input byte stream
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,   // [7:0] rx_byte
    // result stream
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [15:0] m_tdata    // [3:0] event_res, [11:4] out_char, [12] echo_enabled
);
    import scld_pkg::*;

    localparam int AW = $clog2(LINE_MAX);
    localparam int LW = $clog2(LINE_MAX + 1);

    scld_state_t state_reg, state_next;

    logic [LW-1:0]    line_len_reg, line_len_next;
    logic             echo_on_reg, echo_on_next;
    logic [POS_W-1:0] scan_pos_reg, scan_pos_next;
    logic             cmp_valid_reg;
    logic [POS_W-1:0] cmp_pos_reg;
    scld_res_t        res_reg, res_next;
    scld_res_t        m_data_reg, m_data_next;
    logic             m_valid_reg, m_valid_next;

    logic             in_accept;
    logic             out_free;
    logic             wr_en;
    logic             rd_en;
    logic             match_clear;
    logic [7:0]       rd_data;
    scld_cmp_t        cmp;
    scld_event_t      match_code;

    assign in_accept = s_tvalid && s_tready;
    assign out_free  = !m_valid_reg || m_tready;

    // Line buffer: written at the current length, read during the scan
    scld_line_ram #(
        .DEPTH (LINE_MAX),
        .AW    (AW)
    ) u_ram (
        .aclk    (aclk),
        .wr_en   (wr_en),
        .wr_addr (line_len_reg[AW-1:0]),
        .wr_data (s_tdata),
        .rd_en   (rd_en),
        .rd_addr ({{(AW-POS_W){1'b0}}, scan_pos_reg}),
        .rd_data (rd_data)
    );

    // Read data is registered and lands in the cycle after its address; positions past the line are absent
    assign cmp.valid   = cmp_valid_reg;
    assign cmp.pos     = cmp_pos_reg;
    assign cmp.data    = rd_data;
    assign cmp.present = ({{(LW-POS_W){1'b0}}, cmp_pos_reg} < line_len_reg);

    scld_matcher u_match (
        .aclk    (aclk),
        .aresetn (aresetn),
        .clear   (match_clear),
        .cmp     (cmp),
        .code    (match_code)
    );

    // Next state
    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE: begin
                if (in_accept) begin
                    if (s_tdata == CH_CR && line_len_reg != '0) begin
                        state_next = ST_SCAN;
                    end else begin
                        state_next = ST_OUT;
                    end
                end
            end
            ST_SCAN: begin
                if (scan_pos_reg == POS_W'(SCAN_LEN - 1)) begin
                    state_next = ST_DRAIN;
                end
            end
            ST_DRAIN:  state_next = ST_DECIDE;
            ST_DECIDE: state_next = ST_OUT;
            ST_OUT: begin
                if (out_free) begin
                    state_next = ST_IDLE;
                end
            end
            default:   state_next = ST_IDLE;
        endcase
    end

    // Outputs and datapath updates
    always_comb begin
        s_tready      = 1'b0;
        wr_en         = 1'b0;
        rd_en         = 1'b0;
        match_clear   = 1'b0;
        line_len_next = line_len_reg;
        echo_on_next  = echo_on_reg;
        scan_pos_next = scan_pos_reg;
        res_next      = res_reg;
        m_data_next   = m_data_reg;
        m_valid_next  = m_valid_reg && !m_tready;

        unique case (state_reg)
            ST_IDLE: begin
                s_tready = 1'b1;
                if (s_tvalid) begin
                    res_next.ev   = EV_NONE;
                    res_next.ch   = 8'h00;
                    res_next.echo = echo_on_reg;
                    if (s_tdata == CH_CR) begin
                        // non-empty line: scan first, length cleared on decide
                        if (line_len_reg == '0) begin
                            res_next.ev = EV_EMPTY;
                        end
                        match_clear   = 1'b1;
                        scan_pos_next = '0;
                    end else if (s_tdata == CH_BS) begin
                        if (line_len_reg != '0) begin
                            line_len_next = line_len_reg - LW'(1);
                            res_next.ev   = EV_ERASE;
                        end
                    end else if (line_len_reg < LW'(LINE_MAX)) begin
                        wr_en         = 1'b1;
                        line_len_next = line_len_reg + LW'(1);
                        if (echo_on_reg) begin
                            res_next.ev = EV_ECHO;
                            res_next.ch = s_tdata;
                        end
                    end else begin
                        line_len_next = '0;
                        res_next.ev   = EV_TOO_LONG;
                    end
                end
            end
            ST_SCAN: begin
                rd_en         = 1'b1;
                scan_pos_next = scan_pos_reg + POS_W'(1);
            end
            ST_DRAIN: begin
                // last compare folds into the matcher this cycle
            end
            ST_DECIDE: begin
                line_len_next = '0;
                if (match_code == EV_ECHO_ON) begin
                    echo_on_next = 1'b1;
                end else if (match_code == EV_ECHO_OFF) begin
                    echo_on_next = 1'b0;
                end
                res_next.ev   = match_code;
                res_next.ch   = 8'h00;
                res_next.echo = echo_on_next;
            end
            ST_OUT: begin
                if (out_free) begin
                    m_data_next  = res_reg;
                    m_valid_next = 1'b1;
                end
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= ST_IDLE;
            line_len_reg  <= '0;
            echo_on_reg   <= 1'b1;
            scan_pos_reg  <= '0;
            cmp_valid_reg <= 1'b0;
            m_valid_reg   <= 1'b0;
        end else begin
            state_reg     <= state_next;
            line_len_reg  <= line_len_next;
            echo_on_reg   <= echo_on_next;
            scan_pos_reg  <= scan_pos_next;
            cmp_valid_reg <= rd_en;
            m_valid_reg   <= m_valid_next;
        end
    end

    // Payload registers
    always_ff @(posedge aclk) begin
        cmp_pos_reg <= scan_pos_reg;
        res_reg     <= res_next;
        m_data_reg  <= m_data_next;
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = {3'b000, m_data_reg.echo, m_data_reg.ch, m_data_reg.ev};

    // Checks
    a_len_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        line_len_reg <= LW'(LINE_MAX))
        else $error("line length past buffer size");

    a_one_at_a_time: assert property (@(posedge aclk) disable iff (!aresetn)
        in_accept |=> !s_tready)
        else $error("second byte taken while one is in flight");

    a_scan_nonempty: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_DECIDE) |-> (line_len_reg != '0))
        else $error("decode of an empty line");

    a_echo_only_on_decide: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg != ST_DECIDE) |=> $stable(echo_on_reg))
        else $error("echo setting changed outside a decode");

    a_cmp_in_scan: assert property (@(posedge aclk) disable iff (!aresetn)
        cmp_valid_reg |-> (state_reg == ST_SCAN || state_reg == ST_DRAIN))
        else $error("compare step outside the buffer scan");

endmodule

@@ tb/sv/scld_result_checker.sv @@
`timescale 1ns / 100ps
// Result checker for the serial command line decoder testbench.
// Tracks line buffer and echo state per accepted byte, compares each result beat.
// Depends on scld_pkg (event codes, control characters).
module scld_result_checker #(
    parameter int LINE_MAX = 64
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    input  logic        s_tready,
    input  logic [7:0]  s_tdata,
    input  logic        m_tvalid,
    input  logic        m_tready,
    input  logic [15:0] m_tdata,
    output int          mismatch_count,
    output int          pending_count,
    output int          checked_count,
    output logic [15:0] events_seen
);
    import scld_pkg::*;

    // parameter text starts after "set echo" plus one separator character
    localparam int PARAM_POS = 9;

    typedef struct packed {
        logic [31:0] seq;
        scld_event_t ev;
        logic [7:0]  ch;
        logic        echo;
    } byte_result_t;

    logic [7:0]   line_mem [LINE_MAX];
    int unsigned  line_len;
    logic         echo_st;
    int unsigned  bytes_in;
    byte_result_t expected_q [$];

    task automatic flag_mismatch(input string msg);
        mismatch_count++;
        $display("tb: mismatch: %s", msg);
    endtask

    // characters at or past the line end never match
    function automatic bit line_holds(input int unsigned pos, input string word);
        int unsigned p;
        for (int k = 0; k < word.len(); k++) begin
            p = pos + k;
            if (p >= line_len || p >= LINE_MAX) return 1'b0;
            if (line_mem[p] != word[k]) return 1'b0;
        end
        return 1'b1;
    endfunction

    function automatic scld_event_t decode_line();
        if (line_holds(0, "print version")) return EV_VERSION;
        if (line_holds(0, "say hello")) return EV_HELLO;
        if (line_holds(0, "set echo")) begin
            if (line_holds(PARAM_POS, "on")) begin
                echo_st = 1'b1;
                return EV_ECHO_ON;
            end
            if (line_holds(PARAM_POS, "off")) begin
                echo_st = 1'b0;
                return EV_ECHO_OFF;
            end
            return EV_BAD_PARAM;
        end
        return EV_INVALID;
    endfunction

    function automatic byte_result_t apply_byte(input logic [7:0] rx);
        byte_result_t r;
        r.seq = bytes_in;
        r.ev  = EV_NONE;
        r.ch  = 8'h00;
        bytes_in++;
        if (rx == CH_CR) begin
            r.ev = (line_len == 0) ? EV_EMPTY : decode_line();
            line_len = 0;
        end else if (rx == CH_BS) begin
            if (line_len > 0) begin
                line_len--;
                r.ev = EV_ERASE;
            end
        end else if (line_len < LINE_MAX) begin
            line_mem[line_len] = rx;
            line_len++;
            if (echo_st) begin
                r.ev = EV_ECHO;
                r.ch = rx;
            end
        end else begin
            // full line: byte dropped and line discarded
            line_len = 0;
            r.ev = EV_TOO_LONG;
        end
        r.echo = echo_st;
        return r;
    endfunction

    task automatic check_result(input logic [15:0] beat);
        byte_result_t want;
        if (expected_q.size() == 0) begin
            flag_mismatch($sformatf("result %h with no byte outstanding", beat));
            return;
        end
        want = expected_q.pop_front();
        checked_count++;
        events_seen[want.ev] = 1'b1;
        if (beat[3:0] !== want.ev)
            flag_mismatch($sformatf("byte %0d: event_res %0d, expected %0d",
                                    want.seq, beat[3:0], want.ev));
        if (beat[11:4] !== want.ch)
            flag_mismatch($sformatf("byte %0d: out_char %h, expected %h",
                                    want.seq, beat[11:4], want.ch));
        if (beat[12] !== want.echo)
            flag_mismatch($sformatf("byte %0d: echo_enabled %b, expected %b",
                                    want.seq, beat[12], want.echo));
        if (beat[15:13] !== 3'b000)
            flag_mismatch($sformatf("byte %0d: pad bits %b, expected 000",
                                    want.seq, beat[15:13]));
    endtask

    always @(posedge aclk) begin
        if (!aresetn) begin
            line_len       = 0;
            echo_st        = 1'b1;
            bytes_in       = 0;
            expected_q.delete();
            mismatch_count = 0;
            checked_count  = 0;
            events_seen    = '0;
        end else begin
            if (m_tvalid && m_tready) check_result(m_tdata);
            if (s_tvalid && s_tready) expected_q.push_back(apply_byte(s_tdata));
        end
        pending_count = expected_q.size();
    end

endmodule

@@ tb/sv/serial_command_line_decoder_tb.sv @@
`timescale 1ns / 100ps
// Testbench top for serial_command_line_decoder: byte stimulus, result back-pressure,
// watchdog and verdict. Depends on scld_pkg, scld_result_checker and the block itself.
module serial_command_line_decoder_tb;
    import scld_pkg::*;

    localparam int LINE_MAX     = 64;
    localparam int RANDOM_BYTES = 1250;
    localparam int CALM_BYTES   = 200;   // final stretch with no idling on either side
    localparam int STALL_LIMIT  = 3000;  // cycles without any transaction before giving up
    localparam int HOLD_AFTER   = 300;   // results checked before the long receiver hold-off
    localparam int HOLD_CYCLES  = 400;
    localparam int TAIL_CYCLES  = 40;    // outlasts the longest byte-to-result path, catches stray results

    // Opening bytes: CR and BS on an empty line, both byte extremes, erase,
    // then a line of odd bytes (zero byte included earlier) ending in CR -> invalid
    localparam int OPENING_LEN = 11;
    localparam logic [7:0] OPENING [OPENING_LEN] = '{
        CH_CR, CH_BS, 8'h00, 8'hFF, CH_BS, CH_BS, 8'h80, 8'h7F, 8'h01, 8'hFE, CH_CR
    };

    logic        aclk     = 1'b0;
    logic        aresetn  = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [7:0]  s_tdata  = 8'h00;   // [7:0] rx_byte
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [15:0] m_tdata;            // [3:0] event_res, [11:4] out_char, [12] echo_enabled

    int          mismatch_count;
    int          pending_count;
    int          checked_count;
    logic [15:0] events_seen;

    int          bytes_sent  = 0;
    int          idle_cycles = 0;
    bit          calm        = 1'b0;  // set near the end: no more random idling
    logic [7:0]  line_q [$];          // bytes of the line being typed

    always #6 aclk = ~aclk;

    serial_command_line_decoder #(
        .LINE_MAX (LINE_MAX)
    ) DUT (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    scld_result_checker #(
        .LINE_MAX (LINE_MAX)
    ) checker_i (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .s_tvalid       (s_tvalid),
        .s_tready       (s_tready),
        .s_tdata        (s_tdata),
        .m_tvalid       (m_tvalid),
        .m_tready       (m_tready),
        .m_tdata        (m_tdata),
        .mismatch_count (mismatch_count),
        .pending_count  (pending_count),
        .checked_count  (checked_count),
        .events_seen    (events_seen)
    );

    // Watchdog: any stretch this long with no transaction on either side is a hang
    always @(posedge aclk) begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= STALL_LIMIT) begin
            $display("tb: no transaction for %0d cycles, %0d results still due",
                     idle_cycles, pending_count);
            $display("tb: failure");
            $finish;
        end
    end

    // Receiver: random ready bursts, plus one long hold-off so the block backs up
    // and stalls its input while the sender keeps offering bytes
    initial begin : receiver
        bit held;
        held = 1'b0;
        wait (aresetn);
        @(negedge aclk);
        forever begin
            if (!held && checked_count >= HOLD_AFTER) begin
                held = 1'b1;
                m_tready <= 1'b0;
                repeat (HOLD_CYCLES) @(negedge aclk);
            end else if (!calm && $urandom_range(0, 7) == 0) begin
                m_tready <= 1'b0;
                repeat ($urandom_range(1, 14)) @(negedge aclk);
            end else begin
                m_tready <= 1'b1;
                @(negedge aclk);
            end
        end
    end

    // One byte transaction; entered and left at a falling edge.
    // tvalid stays high between back-to-back bytes.
    task automatic send_byte(input logic [7:0] b);
        if (!calm && $urandom_range(0, 4) == 0) begin
            s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 14)) @(negedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= b;
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        @(negedge aclk);
        bytes_sent++;
    endtask

    // Sender pause: stop offering until every outstanding result is back
    task automatic wait_drained();
        s_tvalid <= 1'b0;
        @(negedge aclk);
        while (pending_count != 0) @(negedge aclk);
    endtask

    function automatic logic [7:0] plain_char();
        logic [7:0] c;
        do c = 8'($urandom_range(0, 255)); while (c == CH_CR || c == CH_BS);
        return c;
    endfunction

    task automatic add_text(input string t);
        for (int k = 0; k < t.len(); k++) line_q.push_back(t[k]);
    endtask

    task automatic add_tail();
        repeat ($urandom_range(0, 3)) line_q.push_back(plain_char());
    endtask

    // Full command lines; the double space case leaves "on" one place too far
    function automatic string pick_command();
        case ($urandom_range(0, 4))
            0:       return "print version";
            1:       return "say hello";
            2:       return "set echo on";
            3:       return "set echo off";
            default: return "set echo  on";
        endcase
    endfunction

    // Build one line into line_q, CR included. Mostly well-formed commands with
    // random tails and separators; the rest truncated, corrupted, noisy, overlong or empty.
    task automatic compose_line(input int kind);
        string cmd;
        int    idx;
        line_q.delete();
        case (kind)
            0: begin
                add_text("print version");
                add_tail();
            end
            1: begin
                add_text("say hello");
                add_tail();
            end
            2, 3: begin
                add_text("set echo");
                line_q.push_back(plain_char());   // separator, any character
                case ($urandom_range(0, 3))
                    0:       add_text("on");
                    1:       add_text("off");
                    2:       add_text("of");
                    default: add_tail();
                endcase
                add_tail();
            end
            4: begin
                // cut short: parameter or command runs past the line end
                cmd = pick_command();
                add_text(cmd.substr(0, $urandom_range(0, cmd.len() - 2)));
            end
            5: begin
                // one bit flipped somewhere in a command
                cmd = pick_command();
                add_text(cmd);
                idx = $urandom_range(0, line_q.size() - 1);
                line_q[idx] = line_q[idx] ^ (8'h01 << $urandom_range(0, 7));
            end
            6: begin
                // raw noise, backspace heavy; stray CRs split it into short lines
                repeat ($urandom_range(0, 20)) begin
                    if ($urandom_range(0, 3) == 0)
                        line_q.push_back(CH_BS);
                    else
                        line_q.push_back(8'($urandom_range(0, 255)));
                end
            end
            7: begin
                // fill the line to the limit, then overflow it or edit at the limit
                repeat (LINE_MAX) line_q.push_back(plain_char());
                case ($urandom_range(0, 2))
                    0: ;
                    1: repeat ($urandom_range(1, 3)) line_q.push_back(plain_char());
                    default: begin
                        line_q.push_back(CH_BS);
                        line_q.push_back(plain_char());
                    end
                endcase
            end
            8: begin
                repeat ($urandom_range(0, 2)) line_q.push_back(CH_BS);
            end
            default: begin
                // typing mistakes fixed with backspace
                cmd = pick_command();
                for (int k = 0; k < cmd.len(); k++) begin
                    if ($urandom_range(0, 5) == 0) begin
                        line_q.push_back(plain_char());
                        line_q.push_back(CH_BS);
                    end
                    line_q.push_back(cmd[k]);
                end
            end
        endcase
        line_q.push_back(CH_CR);
    endtask

    initial begin : stimulus
        int line_no;
        int kind;
        line_no = 0;

        repeat (10) @(negedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);

        for (int k = 0; k < OPENING_LEN; k++) send_byte(OPENING[k]);
        wait_drained();

        // First ten lines step through every line shape, then random shapes.
        // Overlong lines are thinned out so they do not swamp the byte count.
        while (bytes_sent < OPENING_LEN + RANDOM_BYTES) begin
            calm = (bytes_sent >= OPENING_LEN + RANDOM_BYTES - CALM_BYTES);
            if (line_no < 10) begin
                kind = line_no;
            end else begin
                kind = $urandom_range(0, 9);
                if (kind == 7 && $urandom_range(0, 3) != 0) kind = 6;
            end
            compose_line(kind);
            for (int k = 0; k < line_q.size(); k++) send_byte(line_q[k]);
            // no pause around the receiver hold-off, so the sender keeps offering then
            if (!calm && $urandom_range(0, 19) == 0 &&
                (checked_count < HOLD_AFTER - 10 || checked_count > HOLD_AFTER + 10))
                wait_drained();
            line_no++;
        end

        // Let the last results through, then watch a while for stray ones
        wait_drained();
        repeat (TAIL_CYCLES) @(negedge aclk);

        $display("tb: %0d bytes in %0d lines sent, %0d results checked, %0d mismatches",
                 bytes_sent, line_no, checked_count, mismatch_count);
        $display("tb: event codes produced, one bit per code from 0 up: %011b",
                 events_seen[10:0]);
        if (mismatch_count == 0 && pending_count == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end

endmodule
